// ----- hw/rtl/vrsc_pkg.sv -----
package vrsc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_DIST   = 2'd0,
    OP_LOAD_DEMAND = 2'd1,
    OP_VISIT       = 2'd2
  } op_t;

  localparam logic CFG_VEHICLE_CAPACITY = 1'b0;
  localparam logic CFG_MAX_ROUTE_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  node_a;
    logic [7:0]  node_b;
    logic [23:0] load_value;
    logic        tour_end;
  } item_t;

  typedef struct packed {
    logic [39:0] total_length;
    logic [8:0]  route_count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_PC,
    S_RD_C0,
    S_RD_P0,
    S_RD_0C,
    S_CAP,
    S_EVAL,
    S_UPD,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RD_PC,
    RD_C0,
    RD_P0,
    RD_0C
  } rd_sel_t;

  typedef struct packed {
    logic    wr_dist;
    logic    wr_demand;
    logic    take_visit;
    rd_sel_t rd_sel;
    logic    cap_pc;
    logic    cap_c0;
    logic    cap_p0;
    logic    cap_0c;
    logic    eval;
    logic    update;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic slot_free;
  } status_t;

endpackage

// ----- hw/rtl/vehicle_route_split_cost_core.sv -----
// Scores a customer tour for capacitated vehicle routing with a route-length
// limit. Distance (16.8 fixed point) and demand loads write straight into
// their RAMs. A visit runs from its transfer through the four distance
// lookups it needs (p-c, c-depot, p-depot, depot-c), one after another
// through the single read port of the distance RAM, then a step to capture
// the last lookup, an evaluate and an update step; item_stall holds off new
// items until it is done. A visit marked as tour end then adds a step to
// load the result register, held while that register still holds an
// untaken result. Results leave through a registered output, so loads and
// visits keep flowing while a result waits.
module vehicle_route_split_cost_core import vrsc_pkg::*; #(
  parameter int NODE_COUNT = 256,
  parameter int DIST_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  vrsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .operation  (item.operation),
    .status     (status),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  vrsc_dp #(
    .NODE_COUNT (NODE_COUNT),
    .DIST_BITS  (DIST_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_stall (result_stall),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- hw/rtl/vrsc_ram.sv -----
module vrsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/vrsc_ctrl.sv -----
module vrsc_ctrl import vrsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [1:0] operation,
  input  status_t    status,
  output logic       item_stall,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && operation == OP_VISIT) begin
          state_next = S_RD_PC;
        end
      end
      S_RD_PC: state_next = S_RD_C0;
      S_RD_C0: state_next = S_RD_P0;
      S_RD_P0: state_next = S_RD_0C;
      S_RD_0C: state_next = S_CAP;
      S_CAP:   state_next = S_EVAL;
      S_EVAL:  state_next = S_UPD;
      S_UPD:   state_next = status.last ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (status.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_PC;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_LOAD_DIST:   cmd.wr_dist = 1'b1;
            OP_LOAD_DEMAND: cmd.wr_demand = 1'b1;
            OP_VISIT:       cmd.take_visit = 1'b1;
            default:        cmd.wr_dist = 1'b0;
          endcase
        end
      end
      S_RD_PC: cmd.rd_sel = RD_PC;
      S_RD_C0: begin
        cmd.rd_sel = RD_C0;
        cmd.cap_pc = 1'b1;
      end
      S_RD_P0: begin
        cmd.rd_sel = RD_P0;
        cmd.cap_c0 = 1'b1;
      end
      S_RD_0C: begin
        cmd.rd_sel = RD_0C;
        cmd.cap_p0 = 1'b1;
      end
      S_CAP:  cmd.cap_0c = 1'b1;
      S_EVAL: cmd.eval = 1'b1;
      S_UPD:  cmd.update = 1'b1;
      S_EMIT: cmd.emit = status.slot_free;
      default: cmd.eval = 1'b0;
    endcase
  end

endmodule

// ----- hw/rtl/vrsc_dp.sv -----
module vrsc_dp import vrsc_pkg::*; #(
  parameter int NODE_COUNT = 256,
  parameter int DIST_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  cmd_t        cmd,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        result_stall,
  output status_t     status,
  output logic        result_valid,
  output result_t     result
);

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int DIST_AW    = 2 * NODE_W;
  localparam int DIST_DEPTH = 1 << DIST_AW;
  localparam int RECIP      = (65536 + NODE_COUNT - 1) / NODE_COUNT;
  localparam logic [16:0] RECIP_V = 17'(RECIP);
  localparam logic [7:0]  NC8     = 8'(NODE_COUNT);
  localparam logic [NODE_W-1:0] DEPOT = '0;

  // node number reduced modulo the node count, by reciprocal multiply (taken as is for 256 nodes or more)
  function automatic logic [NODE_W-1:0] node_of(input logic [7:0] v);
    logic [24:0] prod;
    logic [7:0]  q;
    logic [15:0] qn;
    logic [7:0]  r;
    prod = {17'd0, v} * {8'd0, RECIP_V};
    q    = prod[23:16];
    qn   = {8'd0, q} * {8'd0, NC8};
    r    = v - qn[7:0];
    if (NODE_COUNT >= 256) begin
      return NODE_W'(v);
    end else begin
      return NODE_W'(r);
    end
  endfunction

  logic [15:0]          vehicle_capacity;
  logic [31:0]          max_route_length;

  logic [NODE_W-1:0]    c_node;
  logic [NODE_W-1:0]    p_node;
  logic                 last;
  logic [DIST_BITS-1:0] d_pc;
  logic [DIST_BITS-1:0] d_c0;
  logic [DIST_BITS-1:0] d_p0;
  logic [DIST_BITS-1:0] d_0c;
  logic [15:0]          demand;
  logic                 split;
  logic [31:0]          route_length;
  logic [16:0]          route_load;
  logic [39:0]          tour_sum;
  logic [8:0]           routes;

  logic [DIST_AW-1:0]   dist_waddr;
  logic [DIST_AW-1:0]   dist_raddr;
  logic [DIST_BITS-1:0] dist_rdata;
  logic [15:0]          dem_rdata;

  logic [33:0]          len_sum;
  logic [17:0]          load_sum;
  logic [32:0]          detour;
  logic                 split_next;
  logic [40:0]          closed_sum;
  logic [32:0]          ext_len;
  logic [17:0]          ext_load;
  logic [40:0]          final_sum;

  assign dist_waddr = {node_of(item.node_a), node_of(item.node_b)};

  always_comb begin
    case (cmd.rd_sel)
      RD_PC:   dist_raddr = {p_node, c_node};
      RD_C0:   dist_raddr = {c_node, DEPOT};
      RD_P0:   dist_raddr = {p_node, DEPOT};
      RD_0C:   dist_raddr = {DEPOT, c_node};
      default: dist_raddr = {p_node, c_node};
    endcase
  end

  vrsc_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (DIST_DEPTH)
  ) u_dist_ram (
    .clk   (clk),
    .we    (cmd.wr_dist),
    .waddr (dist_waddr),
    .wdata (DIST_BITS'(item.load_value)),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  vrsc_ram #(
    .WIDTH (16),
    .DEPTH (NODE_COUNT)
  ) u_demand_ram (
    .clk   (clk),
    .we    (cmd.wr_demand),
    .waddr (node_of(item.node_a)),
    .wdata (item.load_value[15:0]),
    .raddr (c_node),
    .rdata (dem_rdata)
  );

  assign len_sum    = 34'(route_length) + 34'(d_pc) + 34'(d_c0);
  assign load_sum   = 18'(route_load) + 18'(demand);
  assign detour     = 33'(d_p0) + 33'(d_0c);
  assign split_next = (p_node != DEPOT) &&
                      ((len_sum > 34'(max_route_length)) ||
                       (load_sum > 18'(vehicle_capacity)) ||
                       (detour < 33'(d_pc)));

  assign closed_sum = 41'(tour_sum) + 41'(route_length) + 41'(d_p0);
  assign ext_len    = 33'(route_length) + 33'(d_pc);
  assign ext_load   = 18'(route_load) + 18'(demand);
  assign final_sum  = 41'(tour_sum) + 41'(route_length) + 41'(d_c0);

  assign status.last      = last;
  assign status.slot_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_capacity <= 16'hFFFF;
      max_route_length <= 32'hFFFF_FFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_VEHICLE_CAPACITY: vehicle_capacity <= cfg_data[15:0];
        CFG_MAX_ROUTE_LENGTH: max_route_length <= cfg_data;
        default:              max_route_length <= max_route_length;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_visit) begin
      c_node <= node_of(item.node_a);
      last   <= item.tour_end;
    end
    if (cmd.cap_pc) begin
      d_pc   <= dist_rdata;
      demand <= dem_rdata;
    end
    if (cmd.cap_c0) begin
      d_c0 <= dist_rdata;
    end
    if (cmd.cap_p0) begin
      d_p0 <= dist_rdata;
    end
    if (cmd.cap_0c) begin
      d_0c <= dist_rdata;
    end
    if (cmd.eval) begin
      split <= split_next;
    end
    if (cmd.emit) begin
      result.total_length <= final_sum[40] ? 40'hFF_FFFF_FFFF : final_sum[39:0];
      result.route_count  <= (routes == 9'h1FF) ? 9'h1FF : routes + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_length <= '0;
      route_load   <= '0;
      tour_sum     <= '0;
      routes       <= '0;
      p_node       <= DEPOT;
      result_valid <= 1'b0;
    end else begin
      if (cmd.update) begin
        p_node <= c_node;
        if (split) begin
          tour_sum     <= closed_sum[40] ? 40'hFF_FFFF_FFFF : closed_sum[39:0];
          routes       <= (routes == 9'h1FF) ? 9'h1FF : routes + 9'd1;
          route_length <= 32'(d_0c);
          route_load   <= 17'(demand);
        end else begin
          route_length <= ext_len[32] ? 32'hFFFF_FFFF : ext_len[31:0];
          route_load   <= ext_load[17] ? 17'h1FFFF : ext_load[16:0];
        end
      end
      if (cmd.emit) begin
        route_length <= '0;
        route_load   <= '0;
        tour_sum     <= '0;
        routes       <= '0;
        p_node       <= DEPOT;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
